// ----- rtl/tile_map_collision_query_core_defines.svh -----
// Assertion macros for the tile map collision query checker.
`ifndef TILE_MAP_COLLISION_QUERY_CORE_DEFINES_SVH
`define TILE_MAP_COLLISION_QUERY_CORE_DEFINES_SVH

// Concurrent check on a given clock and active-low reset.
`define TMCQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tile map collision query check failed");

// Same check on the block clock and reset.
`define TMCQ_CHECK(lbl, prop) \
  `TMCQ_ASSERT(lbl, clk_i, rst_ni, prop)

`endif

// ----- rtl/tmcq_pkg.sv -----
// Shared constants, codes and types of the tile map collision query block.
package tmcq_pkg;

  // Geometry (tile size and map dimensions are powers of two)
  localparam int TILE_SIZE   = 64;
  localparam int MAP_COLS    = 256;
  localparam int MAP_ROWS    = 16;
  localparam int TILE_LOG2   = $clog2(TILE_SIZE);
  localparam int COL_W       = $clog2(MAP_COLS);
  localparam int ROW_W       = $clog2(MAP_ROWS);
  localparam int ADDR_W      = COL_W + ROW_W;
  localparam int STORE_DEPTH = MAP_COLS * MAP_ROWS;
  localparam int SCAN_W      = (COL_W > ROW_W) ? COL_W : ROW_W;

  // Item field widths
  localparam int KIND_W = 3;
  localparam int TCOL_W = 8;
  localparam int TROW_W = 4;
  localparam int CODE_W = 8;
  localparam int POS_W  = 16;
  localparam int SIZE_W = 12;

  // Pixel math: 16-bit position plus 12-bit size, signed, with headroom
  localparam int PX_W = 18;
  localparam int TI_W = PX_W - TILE_LOG2;

  // Configuration
  localparam int MAPW_W    = 15;
  localparam int MAPH_W    = 11;
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 2;
  localparam logic [CODE_W-1:0] SOLID_RESET = CODE_W'(6);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAP_WIDTH  = 2'd0,
    CFG_MAP_HEIGHT = 2'd1,
    CFG_SOLID_FROM = 2'd2
  } cfg_idx_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE  = 3'd0,
    KIND_LEFT   = 3'd1,
    KIND_RIGHT  = 3'd2,
    KIND_TOP    = 3'd3,
    KIND_BOTTOM = 3'd4,
    KIND_FLOOR  = 3'd5
  } kind_e;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [POS_W-1:0]  x;
    logic signed [POS_W-1:0]  y;
    logic [SIZE_W-1:0]        w;
    logic [SIZE_W-1:0]        h;
  } item_t;

  // Clipped rectangle in pixels
  typedef struct packed {
    logic signed [PX_W-1:0] l;
    logic signed [PX_W-1:0] t;
    logic signed [PX_W-1:0] r;
    logic signed [PX_W-1:0] b;
  } box_t;

  // Strip to scan: one coordinate fixed, the other runs first..last
  typedef struct packed {
    logic            axis_row;   // row index runs, fixed is a column
    logic [TI_W-1:0] fixed;
    logic [TI_W-1:0] first;
    logic [TI_W-1:0] last;       // clipped to the store
    logic [TI_W-1:0] corner_a;
    logic [TI_W-1:0] corner_b;
    logic [TI_W-1:0] corner_row;
  } strip_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [CODE_W-1:0] wdata;
  } ram_req_t;

endpackage

// ----- rtl/tmcq_tile_ram.sv -----
// Tile code store: one port, registered read.
module tmcq_tile_ram
  import tmcq_pkg::*;
(
  input  logic              clk_i,
  input  ram_req_t          req_i,
  output logic [CODE_W-1:0] rdata_o
);

  logic [CODE_W-1:0] mem [STORE_DEPTH];
  logic [CODE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.addr];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/tmcq_bounds.sv -----
// Rectangle clipping and strip selection, two register-to-register steps.
module tmcq_bounds
  import tmcq_pkg::*;
(
  input  item_t             item_i,
  input  logic [MAPW_W-1:0] map_w_i,
  input  logic [MAPH_W-1:0] map_h_i,
  input  box_t              box_i,
  output box_t              box_o,
  output strip_t            strip_o
);

  localparam logic signed [PX_W-1:0] PxOne = PX_W'(1);

  function automatic logic [TI_W-1:0] tile_of(logic signed [PX_W-1:0] px);
    if (px[PX_W-1]) begin
      return '0;
    end
    return px[PX_W-1:TILE_LOG2];
  endfunction

  // step 1: clip to the map
  logic signed [PX_W-1:0] x_s, y_s, w_s, h_s, xr, yb, wpx, hpx;

  always_comb begin
    x_s = {{(PX_W-POS_W){item_i.x[POS_W-1]}}, item_i.x};
    y_s = {{(PX_W-POS_W){item_i.y[POS_W-1]}}, item_i.y};
    w_s = {{(PX_W-SIZE_W){1'b0}}, item_i.w};
    h_s = {{(PX_W-SIZE_W){1'b0}}, item_i.h};
    wpx = {{(PX_W-MAPW_W){1'b0}}, map_w_i};
    hpx = {{(PX_W-MAPH_W){1'b0}}, map_h_i};
    xr  = x_s + w_s;
    yb  = y_s + h_s;
    box_o.l = x_s[PX_W-1] ? '0 : x_s;
    box_o.t = y_s[PX_W-1] ? '0 : y_s;
    box_o.r = (xr > wpx) ? wpx : xr;
    box_o.b = (yb > hpx) ? hpx : yb;
  end

  // step 2: a side strip one pixel outside the clipped box; a floor strip one pixel below its top
  logic [TI_W-1:0] tl, tr, tt, tb, tlm1, ttm1, ttp1, last_raw, lim;

  always_comb begin
    tl   = tile_of(box_i.l);
    tr   = tile_of(box_i.r);
    tt   = tile_of(box_i.t);
    tb   = tile_of(box_i.b);
    tlm1 = tile_of(box_i.l - PxOne);
    ttm1 = tile_of(box_i.t - PxOne);
    ttp1 = tile_of(box_i.t + PxOne);

    strip_o.axis_row   = 1'b0;
    strip_o.fixed      = '0;
    strip_o.first      = '0;
    last_raw           = '0;
    strip_o.corner_a   = tl;
    strip_o.corner_b   = tr;
    strip_o.corner_row = tt;

    unique case (item_i.kind)
      KIND_LEFT: begin
        strip_o.axis_row = 1'b1;
        strip_o.fixed    = tlm1;
        strip_o.first    = tt;
        last_raw         = tb;
      end
      KIND_RIGHT: begin
        strip_o.axis_row = 1'b1;
        strip_o.fixed    = tr;
        strip_o.first    = tt;
        last_raw         = tb;
      end
      KIND_TOP: begin
        strip_o.fixed = ttm1;
        strip_o.first = tl;
        last_raw      = tr;
      end
      KIND_BOTTOM: begin
        strip_o.fixed = tb;
        strip_o.first = tl;
        last_raw      = tr;
      end
      KIND_FLOOR: begin
        strip_o.fixed = ttp1;
        strip_o.first = tl;
        last_raw      = tr;
      end
      default: begin
      end
    endcase

    lim = strip_o.axis_row ? TI_W'(MAP_ROWS - 1) : TI_W'(MAP_COLS - 1);
    strip_o.last = (last_raw > lim) ? lim : last_raw;
  end

endmodule

// ----- rtl/tmcq_seq.sv -----
// Sequencer: store clearing, tile writes, corner checks and the strip scan.
module tmcq_seq
  import tmcq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [TCOL_W-1:0] tile_col_i,
  input  logic [TROW_W-1:0] tile_row_i,
  input  logic [CODE_W-1:0] tile_code_i,
  input  logic [POS_W-1:0]  rect_x_i,
  input  logic [POS_W-1:0]  rect_y_i,
  input  logic [SIZE_W-1:0] rect_w_i,
  input  logic [SIZE_W-1:0] rect_h_i,
  input  logic [CODE_W-1:0] solid_from_i,
  input  box_t              box_i,
  input  strip_t            strip_i,
  input  logic [CODE_W-1:0] ram_rdata_i,
  output item_t             item_o,
  output box_t              box_o,
  output ram_req_t          ram_req_o,
  output logic              busy_o,
  output logic              done_o,
  output logic              hit_o
);

  typedef enum logic [9:0] {
    S_CLEAR   = 10'b0000000001,
    S_IDLE    = 10'b0000000010,
    S_CLIP    = 10'b0000000100,
    S_BOUND   = 10'b0000001000,
    S_PLAN    = 10'b0000010000,
    S_CORNER0 = 10'b0000100000,
    S_CORNER1 = 10'b0001000000,
    S_CORNER2 = 10'b0010000000,
    S_SCAN    = 10'b0100000000,
    S_DRAIN   = 10'b1000000000
  } state_e;

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [SCAN_W-1:0] idx_q, idx_d;
  logic              corner_q, corner_d;
  logic              scan_vld_q;
  logic              done_q, done_d;
  logic              hit_q, hit_d;
  item_t             item_q;
  box_t              box_q;
  strip_t            strip_q;

  logic              accept;
  logic              solid;
  logic              fixed_ok, empty, ca_ok, cb_ok, wr_ok;
  logic [ADDR_W-1:0] scan_addr;

  assign accept = start_i && (state_q == S_IDLE);
  // the one shared compare: every tile read goes through it
  assign solid  = (ram_rdata_i >= solid_from_i);

  assign fixed_ok = strip_q.axis_row ? (strip_q.fixed < TI_W'(MAP_COLS))
                                     : (strip_q.fixed < TI_W'(MAP_ROWS));
  assign empty    = !fixed_ok || (strip_q.first > strip_q.last);
  assign ca_ok    = (strip_q.corner_a < TI_W'(MAP_COLS)) &&
                    (strip_q.corner_row < TI_W'(MAP_ROWS));
  assign cb_ok    = (strip_q.corner_b < TI_W'(MAP_COLS)) &&
                    (strip_q.corner_row < TI_W'(MAP_ROWS));
  assign wr_ok    = (int'(tile_col_i) < MAP_COLS) && (int'(tile_row_i) < MAP_ROWS);

  assign scan_addr = strip_q.axis_row ?
                     {idx_q[ROW_W-1:0], strip_q.fixed[COL_W-1:0]} :
                     {strip_q.fixed[ROW_W-1:0], idx_q[COL_W-1:0]};

  always_comb begin
    state_d         = state_q;
    clr_d           = clr_q;
    idx_d           = idx_q;
    corner_d        = corner_q;
    done_d          = 1'b0;
    hit_d           = 1'b0;
    ram_req_o.we    = 1'b0;
    ram_req_o.addr  = scan_addr;
    ram_req_o.wdata = tile_code_i;

    unique case (state_q)
      S_CLEAR: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.addr  = clr_q;
        ram_req_o.wdata = '0;
        if (clr_q == ADDR_W'(STORE_DEPTH - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + ADDR_W'(1);
        end
      end
      S_IDLE: begin
        if (start_i) begin
          if (kind_i == KIND_WRITE) begin
            ram_req_o.we   = wr_ok;
            ram_req_o.addr = {ROW_W'(tile_row_i), COL_W'(tile_col_i)};
            done_d         = 1'b1;
          end else if (kind_i >= KIND_LEFT && kind_i <= KIND_FLOOR) begin
            state_d = S_CLIP;
          end else begin
            done_d = 1'b1;
          end
        end
      end
      S_CLIP:  state_d = S_BOUND;
      S_BOUND: state_d = S_PLAN;
      S_PLAN: begin
        if (solid_from_i == '0) begin
          // every tile is solid: sides always hit, floor corners never air
          done_d  = 1'b1;
          hit_d   = (item_q.kind != KIND_FLOOR);
          state_d = S_IDLE;
        end else if (empty) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (item_q.kind == KIND_FLOOR) begin
          state_d = S_CORNER0;
        end else begin
          idx_d   = strip_q.first[SCAN_W-1:0];
          state_d = S_SCAN;
        end
      end
      S_CORNER0: begin
        ram_req_o.addr = {strip_q.corner_row[ROW_W-1:0], strip_q.corner_a[COL_W-1:0]};
        state_d        = S_CORNER1;
      end
      S_CORNER1: begin
        ram_req_o.addr = {strip_q.corner_row[ROW_W-1:0], strip_q.corner_b[COL_W-1:0]};
        corner_d       = ca_ok && solid;
        state_d        = S_CORNER2;
      end
      S_CORNER2: begin
        if (corner_q || (cb_ok && solid)) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          idx_d   = strip_q.first[SCAN_W-1:0];
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // data of the previous address arrives while the next one is issued
        if (scan_vld_q && solid) begin
          done_d  = 1'b1;
          hit_d   = 1'b1;
          state_d = S_IDLE;
        end else if (idx_q == strip_q.last[SCAN_W-1:0]) begin
          state_d = S_DRAIN;
        end else begin
          idx_d = idx_q + SCAN_W'(1);
        end
      end
      S_DRAIN: begin
        done_d  = 1'b1;
        hit_d   = solid;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      idx_q      <= '0;
      corner_q   <= 1'b0;
      scan_vld_q <= 1'b0;
      done_q     <= 1'b0;
      hit_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      idx_q      <= idx_d;
      corner_q   <= corner_d;
      scan_vld_q <= (state_q == S_SCAN);
      done_q     <= done_d;
      hit_q      <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.kind <= kind_i;
      item_q.x    <= rect_x_i;
      item_q.y    <= rect_y_i;
      item_q.w    <= rect_w_i;
      item_q.h    <= rect_h_i;
    end
    if (state_q == S_CLIP) begin
      box_q <= box_i;
    end
    if (state_q == S_BOUND) begin
      strip_q <= strip_i;
    end
  end

  assign item_o = item_q;
  assign box_o  = box_q;
  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign hit_o  = hit_q;

endmodule

// ----- rtl/tile_map_collision_query_core.sv -----
// Top level of the tile map collision query block.
// After reset the block clears its 4096-entry tile store, one entry per cycle, and holds
// busy_o high while it clears; configuration writes are taken throughout. An item is
// taken when start_i is high and busy_o is low. A tile write or an unknown kind gives its
// result in the next cycle. A side query clips the rectangle and chooses the strip in
// states S_CLIP, S_BOUND and S_PLAN, then reads the strip one tile per cycle through
// the store's single port and one compare against solid_from; a hit or an empty strip
// ends it early. A floor query first reads its two corners in states S_CORNER0 to
// S_CORNER2. Each result is shown on hit_o for one cycle with done_o high and cannot
// be held off; the next item may be taken in that same cycle.
module tile_map_collision_query_core
  import tmcq_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 start_i,
  input  logic [KIND_W-1:0]    kind_i,
  input  logic [TCOL_W-1:0]    tile_col_i,
  input  logic [TROW_W-1:0]    tile_row_i,
  input  logic [CODE_W-1:0]    tile_code_i,
  input  logic [POS_W-1:0]     rect_x_i,
  input  logic [POS_W-1:0]     rect_y_i,
  input  logic [SIZE_W-1:0]    rect_w_i,
  input  logic [SIZE_W-1:0]    rect_h_i,
  output logic                 busy_o,
  output logic                 done_o,
  output logic                 hit_o
);

  logic [MAPW_W-1:0] map_w_q;
  logic [MAPH_W-1:0] map_h_q;
  logic [CODE_W-1:0] solid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_w_q <= '0;
      map_h_q <= '0;
      solid_q <= SOLID_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAP_WIDTH:  map_w_q <= cfg_data_i[MAPW_W-1:0];
        CFG_MAP_HEIGHT: map_h_q <= cfg_data_i[MAPH_W-1:0];
        CFG_SOLID_FROM: solid_q <= cfg_data_i[CODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  item_t             item;
  box_t              box_nxt, box_cur;
  strip_t            strip_nxt;
  ram_req_t          ram_req;
  logic [CODE_W-1:0] ram_rdata;

  tmcq_bounds u_bounds (
    .item_i  (item),
    .map_w_i (map_w_q),
    .map_h_i (map_h_q),
    .box_i   (box_cur),
    .box_o   (box_nxt),
    .strip_o (strip_nxt)
  );

  tmcq_tile_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  tmcq_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .kind_i       (kind_i),
    .tile_col_i   (tile_col_i),
    .tile_row_i   (tile_row_i),
    .tile_code_i  (tile_code_i),
    .rect_x_i     (rect_x_i),
    .rect_y_i     (rect_y_i),
    .rect_w_i     (rect_w_i),
    .rect_h_i     (rect_h_i),
    .solid_from_i (solid_q),
    .box_i        (box_nxt),
    .strip_i      (strip_nxt),
    .ram_rdata_i  (ram_rdata),
    .item_o       (item),
    .box_o        (box_cur),
    .ram_req_o    (ram_req),
    .busy_o       (busy_o),
    .done_o       (done_o),
    .hit_o        (hit_o)
  );

endmodule

// ----- rtl/tmcq_checker.sv -----
// Port-level checks of the tile map collision query block, bound to the top level.
`include "tile_map_collision_query_core_defines.svh"

module tmcq_checker
  import tmcq_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic [KIND_W-1:0] kind_i,
  input logic              busy_o,
  input logic              done_o,
  input logic              hit_o
);

  logic take_write;
  logic take_query;

  assign take_write = start_i && !busy_o && (kind_i == KIND_WRITE);
  assign take_query = start_i && !busy_o && (kind_i >= KIND_LEFT) && (kind_i <= KIND_FLOOR);

  `TMCQ_CHECK(a_done_when_idle, done_o |-> !busy_o)
  `TMCQ_CHECK(a_hit_only_with_done, hit_o |-> done_o)
  `TMCQ_CHECK(a_write_result, take_write |=> (done_o && !hit_o))
  `TMCQ_CHECK(a_query_busy, take_query |=> (busy_o && !done_o))

endmodule

bind tile_map_collision_query_core tmcq_checker u_checker (.*);

// ----- verif/tile_map_collision_query_core_tb.sv -----
// Testbench for the tile map collision query core: directed table, then random items.
`timescale 1ns / 100ps

module tile_map_collision_query_core_tb;
  import tmcq_pkg::*;

  // Kinds beyond the defined set; the block answers them with a miss
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [TCOL_W-1:0] col;
    logic [TROW_W-1:0] row;
    logic [CODE_W-1:0] code;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
  } tile_item_t;

  typedef struct {
    bit               is_cfg;
    cfg_idx_e         idx;
    logic [CFG_W-1:0] val;
    tile_item_t       it;
    bit               pinned;
    logic             pin_hit;
  } dir_row_t;

  typedef struct {
    logic              hit;
    int                seq;
    logic [KIND_W-1:0] kind;
  } pending_hit_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 start_i;
  logic [KIND_W-1:0]    kind_i;
  logic [TCOL_W-1:0]    tile_col_i;
  logic [TROW_W-1:0]    tile_row_i;
  logic [CODE_W-1:0]    tile_code_i;
  logic [POS_W-1:0]     rect_x_i;
  logic [POS_W-1:0]     rect_y_i;
  logic [SIZE_W-1:0]    rect_w_i;
  logic [SIZE_W-1:0]    rect_h_i;
  logic                 busy_o;
  logic                 done_o;
  logic                 hit_o;

  // Typed expectation that rides along with the driven item
  bit   pin_valid;
  logic pin_value;

  // Predictor state
  logic [CODE_W-1:0] tile_codes [MAP_ROWS][MAP_COLS];
  int                map_w_px;
  int                map_h_px;
  logic [CODE_W-1:0] solid_code;

  pending_hit_t pending_hits[$];
  pending_hit_t head;
  tile_item_t   seen_item;
  int           item_seq;
  int           errors;

  tile_map_collision_query_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .start_i     (start_i),
    .kind_i      (kind_i),
    .tile_col_i  (tile_col_i),
    .tile_row_i  (tile_row_i),
    .tile_code_i (tile_code_i),
    .rect_x_i    (rect_x_i),
    .rect_y_i    (rect_y_i),
    .rect_w_i    (rect_w_i),
    .rect_h_i    (rect_h_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .hit_o       (hit_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  task automatic report_mismatch(input string msg);
    $display("%0d ns: mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic int tile_index(input int px);
    return (px < 0) ? 0 : px / TILE_SIZE;
  endfunction

  // Tiles outside the store read as code 0
  function automatic bit tile_solid(input int col, input int row);
    logic [CODE_W-1:0] code;
    code = '0;
    if (col >= 0 && row >= 0 && col < MAP_COLS && row < MAP_ROWS) code = tile_codes[row][col];
    return code >= solid_code;
  endfunction

  function automatic bit strip_hit(input int c0, input int r0, input int c1, input int r1);
    int  c_end;
    int  r_end;
    bit  found;
    c_end = (c1 > MAP_COLS - 1) ? MAP_COLS - 1 : c1;
    r_end = (r1 > MAP_ROWS - 1) ? MAP_ROWS - 1 : r1;
    // with a zero threshold every tile is solid, even for an empty strip
    if (solid_code == '0) return 1'b1;
    found = 1'b0;
    for (int r = r0; r <= r_end; r++)
      for (int c = c0; c <= c_end; c++)
        if (tile_solid(c, r)) found = 1'b1;
    return found;
  endfunction

  function automatic logic predict_hit(input tile_item_t it);
    int x, y, w, h, l, t, r, b, c0, c1, r0;
    logic hit;
    x = int'($signed(it.x));
    y = int'($signed(it.y));
    w = int'(it.w);
    h = int'(it.h);
    l = (x < 0) ? 0 : x;
    t = (y < 0) ? 0 : y;
    r = x + w;
    if (r > map_w_px) r = map_w_px;
    b = y + h;
    if (b > map_h_px) b = map_h_px;
    hit = 1'b0;
    case (it.kind)
      KIND_LEFT: begin
        c0 = tile_index(l - 1);
        hit = strip_hit(c0, tile_index(t), c0, tile_index(b));
      end
      KIND_RIGHT: begin
        c0 = tile_index(r);
        hit = strip_hit(c0, tile_index(t), c0, tile_index(b));
      end
      KIND_TOP: begin
        r0 = tile_index(t - 1);
        hit = strip_hit(tile_index(l), r0, tile_index(r), r0);
      end
      KIND_BOTTOM: begin
        r0 = tile_index(b);
        hit = strip_hit(tile_index(l), r0, tile_index(r), r0);
      end
      KIND_FLOOR: begin
        c0 = tile_index(l);
        c1 = tile_index(r);
        r0 = tile_index(t);
        // both foot corners must be air before the row under the feet counts
        if (!tile_solid(c0, r0) && !tile_solid(c1, r0))
          hit = strip_hit(c0, tile_index(t + 1), c1, tile_index(t + 1));
      end
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // Sample at the rising edge: check results, track config, predict accepted items
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      foreach (tile_codes[r, c]) tile_codes[r][c] = '0;
      map_w_px   = 0;
      map_h_px   = 0;
      solid_code = SOLID_RESET;
      item_seq   = 0;
    end else begin
      if (done_o) begin
        if (pending_hits.size() == 0) begin
          report_mismatch($sformatf("result hit=%b with no item pending", hit_o));
        end else begin
          head = pending_hits.pop_front();
          if (hit_o !== head.hit)
            report_mismatch($sformatf("item %0d kind %0d: hit got %b want %b",
                                      head.seq, head.kind, hit_o, head.hit));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MAP_WIDTH:  map_w_px = int'(cfg_data_i[MAPW_W-1:0]);
          CFG_MAP_HEIGHT: map_h_px = int'(cfg_data_i[MAPH_W-1:0]);
          CFG_SOLID_FROM: solid_code = cfg_data_i[CODE_W-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_o) begin
        seen_item.kind = kind_i;
        seen_item.col  = tile_col_i;
        seen_item.row  = tile_row_i;
        seen_item.code = tile_code_i;
        seen_item.x    = rect_x_i;
        seen_item.y    = rect_y_i;
        seen_item.w    = rect_w_i;
        seen_item.h    = rect_h_i;
        head.hit  = pin_valid ? pin_value : predict_hit(seen_item);
        head.seq  = item_seq;
        head.kind = kind_i;
        pending_hits.push_back(head);
        item_seq++;
        if (kind_i == KIND_WRITE) tile_codes[tile_row_i][tile_col_i] = tile_code_i;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic issue_item(input tile_item_t it, input bit pinned, input logic ph,
                            input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start_i = 1'b0;
      @(negedge clk_i);
    end
    start_i     = 1'b1;
    kind_i      = it.kind;
    tile_col_i  = it.col;
    tile_row_i  = it.row;
    tile_code_i = it.code;
    rect_x_i    = it.x;
    rect_y_i    = it.y;
    rect_w_i    = it.w;
    rect_h_i    = it.h;
    pin_valid   = pinned;
    pin_value   = ph;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  // Registers change only with nothing in flight
  task automatic program_reg(input cfg_idx_e idx, input int val);
    start_i = 1'b0;
    while (pending_hits.size() != 0) @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = CFG_W'(val);
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  task automatic randomize_config();
    int w_px, h_px, sf;
    case ($urandom_range(9))
      0: w_px = 0;
      1: w_px = 16384;
      2: w_px = 32767;
      3: w_px = 2048;
      default: w_px = $urandom_range(0, 16384);
    endcase
    case ($urandom_range(9))
      0: h_px = 0;
      1: h_px = 1024;
      2: h_px = 2047;
      3: h_px = 128;
      default: h_px = $urandom_range(0, 1024);
    endcase
    case ($urandom_range(9))
      0: sf = 0;
      1: sf = 255;
      2: sf = 6;
      default: sf = $urandom_range(1, 255);
    endcase
    program_reg(CFG_MAP_WIDTH, w_px);
    program_reg(CFG_MAP_HEIGHT, h_px);
    program_reg(CFG_SOLID_FROM, sf);
  endtask

  // Most items land on the first 32 columns so writes and queries meet
  function automatic tile_item_t make_item();
    tile_item_t it;
    int pick;
    pick = $urandom_range(99);
    if (pick < 30) it.kind = KIND_WRITE;
    else if (pick < 34) it.kind = $urandom_range(1) ? KIND_SPARE_HI : KIND_SPARE_LO;
    else it.kind = KIND_W'($urandom_range(1, 5));
    it.col  = TCOL_W'($urandom);
    it.row  = TROW_W'($urandom);
    it.code = CODE_W'($urandom);
    it.x    = POS_W'($urandom);
    it.y    = POS_W'($urandom);
    it.w    = SIZE_W'($urandom);
    it.h    = SIZE_W'($urandom);
    if ($urandom_range(99) < 80) begin
      if ($urandom_range(3) != 0) it.col = TCOL_W'($urandom_range(0, 31));
      if ($urandom_range(9) < 7) it.x = POS_W'(int'($urandom_range(0, 2200)) - 100);
      else it.x = POS_W'(int'($urandom_range(0, 16600)) - 100);
      it.y = POS_W'(int'($urandom_range(0, 1150)) - 60);
      it.w = ($urandom_range(9) == 0) ? SIZE_W'($urandom_range(0, 4095))
                                      : SIZE_W'($urandom_range(0, 200));
      it.h = ($urandom_range(9) == 0) ? SIZE_W'($urandom_range(0, 4095))
                                      : SIZE_W'($urandom_range(0, 200));
    end
    return it;
  endfunction

  function automatic dir_row_t qrow(input logic [KIND_W-1:0] k, input int x, input int y,
                                    input int w, input int h, input bit pinned,
                                    input logic ph);
    dir_row_t d;
    d.is_cfg  = 1'b0;
    d.idx     = CFG_MAP_WIDTH;
    d.val     = '0;
    d.it.kind = k;
    d.it.col  = '0;
    d.it.row  = '0;
    d.it.code = '0;
    d.it.x    = POS_W'(x);
    d.it.y    = POS_W'(y);
    d.it.w    = SIZE_W'(w);
    d.it.h    = SIZE_W'(h);
    d.pinned  = pinned;
    d.pin_hit = ph;
    return d;
  endfunction

  // A write always answers with a miss
  function automatic dir_row_t wrow(input int col, input int row, input int code);
    dir_row_t d;
    d = qrow(KIND_WRITE, 0, 0, 0, 0, 1'b1, 1'b0);
    d.it.col  = TCOL_W'(col);
    d.it.row  = TROW_W'(row);
    d.it.code = CODE_W'(code);
    return d;
  endfunction

  function automatic dir_row_t crow(input cfg_idx_e idx, input int val);
    dir_row_t d;
    d = qrow(KIND_WRITE, 0, 0, 0, 0, 1'b0, 1'b0);
    d.is_cfg = 1'b1;
    d.idx    = idx;
    d.val    = CFG_W'(val);
    return d;
  endfunction

  initial begin
    dir_row_t rows[$];
    int       idle_pct [3];
    int       drain;
    idle_pct[0] = 9;
    idle_pct[1] = 63;
    idle_pct[2] = 0;
    errors      = 0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_MAP_WIDTH;
    cfg_data_i  = '0;
    start_i     = 1'b0;
    kind_i      = KIND_WRITE;
    tile_col_i  = '0;
    tile_row_i  = '0;
    tile_code_i = '0;
    rect_x_i    = '0;
    rect_y_i    = '0;
    rect_w_i    = '0;
    rect_h_i    = '0;
    pin_valid   = 1'b0;
    pin_value   = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: zero-size map, store empty, so nothing is solid
    rows.push_back(qrow(KIND_LEFT, 0, 0, 0, 0, 1'b1, 1'b0));
    rows.push_back(qrow(KIND_FLOOR, 100, 100, 50, 50, 1'b1, 1'b0));
    rows.push_back(wrow(255, 15, 255));
    rows.push_back(wrow(0, 0, 6));
    rows.push_back(wrow(1, 1, 200));
    rows.push_back(qrow(KIND_SPARE_LO, -1, -1, 4095, 4095, 1'b1, 1'b0));
    rows.push_back(qrow(KIND_SPARE_HI, 32767, -32768, 0, 4095, 1'b1, 1'b0));
    rows.push_back(crow(CFG_MAP_WIDTH, 16384));
    rows.push_back(crow(CFG_MAP_HEIGHT, 1024));
    rows.push_back(qrow(KIND_LEFT, 64, 0, 10, 10, 1'b0, 1'b0));
    rows.push_back(qrow(KIND_RIGHT, -32768, -32768, 4095, 4095, 1'b0, 1'b0));
    rows.push_back(qrow(KIND_TOP, 32767, 32767, 4095, 4095, 1'b0, 1'b0));
    rows.push_back(qrow(KIND_BOTTOM, 16000, 900, 4095, 4095, 1'b0, 1'b0));
    rows.push_back(qrow(KIND_FLOOR, 70, 63, 100, 10, 1'b0, 1'b0));
    rows.push_back(qrow(KIND_FLOOR, 0, 0, 10, 10, 1'b0, 1'b0));
    rows.push_back(qrow(KIND_TOP, 64, 64, 0, 0, 1'b0, 1'b0));
    // zero threshold: side strips always hit, floor corners are always solid
    rows.push_back(crow(CFG_SOLID_FROM, 0));
    rows.push_back(qrow(KIND_LEFT, 500, 500, 20, 20, 1'b1, 1'b1));
    rows.push_back(qrow(KIND_BOTTOM, 100, 100, 0, 0, 1'b1, 1'b1));
    rows.push_back(qrow(KIND_FLOOR, 500, 500, 20, 20, 1'b1, 1'b0));
    rows.push_back(wrow(3, 2, 0));
    rows.push_back(crow(CFG_SOLID_FROM, 255));
    rows.push_back(qrow(KIND_RIGHT, 16320, 0, 4095, 10, 1'b0, 1'b0));
    rows.push_back(qrow(KIND_TOP, 16320, 1024, 63, 10, 1'b0, 1'b0));
    rows.push_back(qrow(KIND_BOTTOM, 16320, 900, 63, 4095, 1'b0, 1'b0));
    rows.push_back(crow(CFG_MAP_WIDTH, 0));
    rows.push_back(crow(CFG_MAP_HEIGHT, 0));
    rows.push_back(crow(CFG_SOLID_FROM, 6));
    rows.push_back(qrow(KIND_RIGHT, 10, 10, 10, 10, 1'b0, 1'b0));
    rows.push_back(crow(CFG_MAP_WIDTH, 32767));
    rows.push_back(crow(CFG_MAP_HEIGHT, 2047));
    rows.push_back(qrow(KIND_BOTTOM, 16000, 1000, 4095, 4095, 1'b0, 1'b0));

    foreach (rows[i]) begin
      if (rows[i].is_cfg) program_reg(rows[i].idx, int'(rows[i].val));
      else issue_item(rows[i].it, rows[i].pinned, rows[i].pin_hit, 0);
    end

    for (int phase = 0; phase < 3; phase++) begin
      for (int n = 0; n < 367; n++) begin
        if (n % 92 == 0) randomize_config();
        issue_item(make_item(), 1'b0, 1'b0, idle_pct[phase]);
      end
    end

    start_i = 1'b0;
    for (drain = 0; drain < 5000 && pending_hits.size() != 0; drain++) @(negedge clk_i);
    if (pending_hits.size() != 0)
      report_mismatch($sformatf("%0d items left with no result", pending_hits.size()));
    // catch any stray strobe after the last result
    repeat (100) @(negedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
